[rtl/rau_pkg.sv]
package rau_pkg;

	localparam int unsigned WORD_WIDTH_DEF = 32;

	typedef enum logic [3:0] {
		ACT_NORM = 4'd0,
		ACT_ADD  = 4'd1,
		ACT_SUB  = 4'd2,
		ACT_MUL  = 4'd3,
		ACT_DIV  = 4'd4,
		ACT_EQ   = 4'd5,
		ACT_NE   = 4'd6,
		ACT_LT   = 4'd7,
		ACT_LE   = 4'd8,
		ACT_GT   = 4'd9,
		ACT_GE   = 4'd10
	} action_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_ZDEN = 2'd1,
		ST_DIV0 = 2'd2,
		ST_OVF  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MUL,
		BK_COMB,
		BK_GCD,
		BK_DIV,
		BK_DONE
	} bk_state_t;

endpackage

[rtl/rau_if.sv]
interface rau_in_if;
	logic        valid;
	logic        ready;
	logic [3:0]  action;
	logic [31:0] a_num;
	logic [31:0] a_den;
	logic [31:0] b_num;
	logic [31:0] b_den;
	modport source (output valid, action, a_num, a_den, b_num, b_den, input ready);
	modport sink   (input valid, action, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] res_num;
	logic [30:0] res_den;
	logic        compare_true;
	logic [1:0]  status;
	modport source (output valid, res_num, res_den, compare_true, status, input ready);
	modport sink   (input valid, res_num, res_den, compare_true, status, output ready);
endinterface

[rtl/rau_front.sv]
module rau_front #(
	parameter int unsigned WORD_WIDTH = rau_pkg::WORD_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	rau_in_if.sink                    in_ch,
	output logic                      q_valid,
	input  logic                      q_ready,
	output logic [3:0]                q_action,
	output logic                      q_early,
	output logic [1:0]                q_status,
	output logic signed [WORD_WIDTH:0] q_an,
	output logic [WORD_WIDTH:0]       q_ad,
	output logic signed [WORD_WIDTH:0] q_bn,
	output logic [WORD_WIDTH:0]       q_bd
);
	localparam int unsigned W = WORD_WIDTH;
	localparam int unsigned QD = 2;

	logic signed [W-1:0] an, ad, bn, bd;
	logic signed [W:0]   an_f, bn_f;
	logic [W:0]          ad_f, bd_f;
	logic                early;
	logic [1:0]          st;

	logic [3:0]          act_q [QD];
	logic                early_q [QD];
	logic [1:0]          st_q [QD];
	logic signed [W:0]   an_q [QD];
	logic [W:0]          ad_q [QD];
	logic signed [W:0]   bn_q [QD];
	logic [W:0]          bd_q [QD];
	logic                wp_q, rp_q;
	logic [1:0]          cnt_q;
	logic                push, pop;

	always_comb begin
		an = in_ch.a_num[W-1:0];
		ad = in_ch.a_den[W-1:0];
		bn = in_ch.b_num[W-1:0];
		bd = in_ch.b_den[W-1:0];
		an_f = ad[W-1] ? -(W+1)'(an) : (W+1)'(an);
		ad_f = ad[W-1] ? -(W+1)'(ad) : (W+1)'(ad);
		bn_f = bd[W-1] ? -(W+1)'(bn) : (W+1)'(bn);
		bd_f = bd[W-1] ? -(W+1)'(bd) : (W+1)'(bd);
		early = 1'b0;
		st = rau_pkg::ST_OK;
		if (in_ch.action > rau_pkg::ACT_GE) begin
			early = 1'b1;
		end else if (ad == '0 || (in_ch.action != rau_pkg::ACT_NORM && bd == '0)) begin
			early = 1'b1;
			st = rau_pkg::ST_ZDEN;
		end else if (in_ch.action == rau_pkg::ACT_DIV && bn == '0) begin
			early = 1'b1;
			st = rau_pkg::ST_DIV0;
		end
	end

	assign in_ch.ready = (cnt_q != 2'(QD));
	assign push = in_ch.valid && in_ch.ready;
	assign q_valid = (cnt_q != '0);
	assign pop = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			act_q[wp_q] <= in_ch.action;
			early_q[wp_q] <= early;
			st_q[wp_q] <= st;
			an_q[wp_q] <= an_f;
			ad_q[wp_q] <= ad_f;
			bn_q[wp_q] <= bn_f;
			bd_q[wp_q] <= bd_f;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	assign q_action = act_q[rp_q];
	assign q_early = early_q[rp_q];
	assign q_status = st_q[rp_q];
	assign q_an = an_q[rp_q];
	assign q_ad = ad_q[rp_q];
	assign q_bn = bn_q[rp_q];
	assign q_bd = bd_q[rp_q];

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'(QD))
		else $error("queue count out of range");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'(QD) |-> !push) else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == '0 |-> !pop) else $error("pop from empty queue");
endmodule

[rtl/rau_back.sv]
module rau_back #(
	parameter int unsigned WORD_WIDTH = rau_pkg::WORD_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_valid,
	output logic                       q_ready,
	input  logic [3:0]                 q_action,
	input  logic                       q_early,
	input  logic [1:0]                 q_status,
	input  logic signed [WORD_WIDTH:0] q_an,
	input  logic [WORD_WIDTH:0]        q_ad,
	input  logic signed [WORD_WIDTH:0] q_bn,
	input  logic [WORD_WIDTH:0]        q_bd,
	rau_out_if.source                  out_ch
);
	localparam int unsigned W = WORD_WIDTH;
	localparam int unsigned DW = 2 * W + 2;
	localparam int unsigned CW = $clog2(DW + 1);

	rau_pkg::bk_state_t state_q, state_d;

	logic [3:0]    act_q;
	logic          an_neg_q, bn_neg_q;
	logic [W:0]    am_q, bm_q, ad_q, bd_q;
	logic [DW-1:0] p1_q, p2_q, p3_q;
	logic          neg_q;
	logic [DW-1:0] mag_q, den_q;
	logic [DW-1:0] gx_q, gy_q;
	// shared restoring divider
	logic [DW-1:0] dq_q, drem_q, ddiv_q;
	logic [CW-1:0] dcnt_q;
	logic          dphase_q;
	logic [DW-1:0] rmag_q;

	logic [31:0]   rn_q;
	logic [30:0]   rd_q;
	logic          cmp_q;
	logic [1:0]    st_q;

	logic [W:0]    m1a, m1b, m2a, m2b, m3a, m3b;
	logic          ln, rn;
	logic [DW:0]   rem_sh;
	logic [DW-1:0] lim;

	assign lim = DW'(1) << (W - 1);
	assign q_ready = (state_q == rau_pkg::BK_IDLE);

	always_comb begin
		unique case (act_q)
			rau_pkg::ACT_MUL: begin
				m1a = am_q; m1b = bm_q; m2a = ad_q; m2b = bd_q;
			end
			rau_pkg::ACT_DIV: begin
				m1a = am_q; m1b = bd_q; m2a = ad_q; m2b = bm_q;
			end
			rau_pkg::ACT_NORM: begin
				m1a = am_q; m1b = (W+1)'(1); m2a = ad_q; m2b = (W+1)'(1);
			end
			default: begin
				m1a = am_q; m1b = bd_q; m2a = bm_q; m2b = ad_q;
			end
		endcase
		m3a = ad_q;
		m3b = bd_q;
	end

	always_comb begin
		ln = an_neg_q;
		rn = (bn_neg_q != (act_q == rau_pkg::ACT_SUB)) && (bm_q != '0);
	end

	// signed compare of l = sl*p1 and r = sr*p2
	logic sl, sr, lt, eqv;
	always_comb begin
		sl = an_neg_q && p1_q != '0;
		sr = bn_neg_q && p2_q != '0;
		eqv = (sl == sr) && (p1_q == p2_q);
		if (sl != sr) lt = sl;
		else if (sl) lt = p1_q > p2_q;
		else lt = p1_q < p2_q;
	end

	assign rem_sh = {drem_q, dq_q[DW-1]};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rau_pkg::BK_IDLE: if (q_valid) state_d = q_early ? rau_pkg::BK_DONE : rau_pkg::BK_MUL;
			rau_pkg::BK_MUL: state_d = rau_pkg::BK_COMB;
			rau_pkg::BK_COMB:
				state_d = (act_q >= rau_pkg::ACT_EQ) ? rau_pkg::BK_DONE : rau_pkg::BK_GCD;
			rau_pkg::BK_GCD: if (gx_q == '0) state_d = rau_pkg::BK_DIV;
			rau_pkg::BK_DIV:
				if (dcnt_q == CW'(DW) && dphase_q) state_d = rau_pkg::BK_DONE;
			rau_pkg::BK_DONE: if (out_ch.ready) state_d = rau_pkg::BK_IDLE;
			default: state_d = rau_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= rau_pkg::BK_IDLE;
		else state_q <= state_d;
	end

	// gcd iterations: one restoring divide per remainder, reused for the final quotients
	logic gdiv_busy_q;
	always_ff @(posedge clk) begin
		unique case (state_q)
			rau_pkg::BK_IDLE: if (q_valid) begin
				act_q <= q_action;
				an_neg_q <= q_an[W];
				bn_neg_q <= q_bn[W];
				am_q <= q_an[W] ? -q_an : q_an;
				bm_q <= q_bn[W] ? -q_bn : q_bn;
				ad_q <= q_ad;
				bd_q <= q_bd;
				rn_q <= '0;
				rd_q <= 31'd1;
				cmp_q <= 1'b0;
				st_q <= q_status;
			end
			rau_pkg::BK_MUL: begin
				p1_q <= m1a * m1b;
				p2_q <= m2a * m2b;
				p3_q <= m3a * m3b;
			end
			rau_pkg::BK_COMB: begin
				unique case (act_q) inside
					rau_pkg::ACT_NORM, rau_pkg::ACT_MUL, rau_pkg::ACT_DIV: begin
						neg_q <= an_neg_q != ((act_q == rau_pkg::ACT_NORM) ? 1'b0 : bn_neg_q);
						mag_q <= p1_q;
						den_q <= p2_q;
						gx_q <= p1_q;
						gy_q <= p2_q;
					end
					rau_pkg::ACT_ADD, rau_pkg::ACT_SUB: begin
						den_q <= p3_q;
						gy_q <= p3_q;
						if (ln == rn) begin
							neg_q <= ln; mag_q <= p1_q + p2_q; gx_q <= p1_q + p2_q;
						end else if (p1_q >= p2_q) begin
							neg_q <= ln; mag_q <= p1_q - p2_q; gx_q <= p1_q - p2_q;
						end else begin
							neg_q <= rn; mag_q <= p2_q - p1_q; gx_q <= p2_q - p1_q;
						end
					end
					default: begin
						unique case (act_q)
							rau_pkg::ACT_EQ: cmp_q <= eqv;
							rau_pkg::ACT_NE: cmp_q <= !eqv;
							rau_pkg::ACT_LT: cmp_q <= lt;
							rau_pkg::ACT_LE: cmp_q <= lt || eqv;
							rau_pkg::ACT_GT: cmp_q <= !lt && !eqv;
							default: cmp_q <= !lt;
						endcase
					end
				endcase
				gdiv_busy_q <= 1'b0;
				dcnt_q <= '0;
			end
			rau_pkg::BK_GCD: if (gx_q != '0) begin
				if (!gdiv_busy_q) begin
					dq_q <= gy_q;
					drem_q <= '0;
					ddiv_q <= gx_q;
					dcnt_q <= '0;
					gdiv_busy_q <= 1'b1;
				end else if (dcnt_q != CW'(DW)) begin
					dq_q <= {dq_q[DW-2:0], rem_sh >= {1'b0, ddiv_q}};
					drem_q <= (rem_sh >= {1'b0, ddiv_q}) ? DW'(rem_sh - {1'b0, ddiv_q})
						: DW'(rem_sh);
					dcnt_q <= dcnt_q + 1'b1;
				end else begin
					gy_q <= gx_q;
					gx_q <= drem_q;
					gdiv_busy_q <= 1'b0;
				end
			end else begin
				// gy_q holds the gcd; divide mag first
				dq_q <= mag_q;
				drem_q <= '0;
				ddiv_q <= gy_q;
				dcnt_q <= '0;
				dphase_q <= 1'b0;
			end
			rau_pkg::BK_DIV: begin
				if (dcnt_q != CW'(DW)) begin
					dq_q <= {dq_q[DW-2:0], rem_sh >= {1'b0, ddiv_q}};
					drem_q <= (rem_sh >= {1'b0, ddiv_q}) ? DW'(rem_sh - {1'b0, ddiv_q})
						: DW'(rem_sh);
					dcnt_q <= dcnt_q + 1'b1;
				end else if (!dphase_q) begin
					rmag_q <= dq_q;
					dq_q <= den_q;
					drem_q <= '0;
					dcnt_q <= '0;
					dphase_q <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	// final result assembly
	logic [DW-1:0] fm, fd;
	logic          fneg, fov;
	always_comb begin
		fm = rmag_q;
		fd = dq_q;
		fneg = neg_q && (fm != '0);
		fov = (fd > lim - 1'b1) || (fneg ? (fm > lim) : (fm > lim - 1'b1));
	end

	logic [DW-1:0] fnum;
	assign fnum = fneg ? -fm : fm;

	logic [31:0] o_num;
	logic [30:0] o_den;
	logic [1:0]  o_st;
	logic        done_num_q;
	always_ff @(posedge clk) begin
		if (state_q == rau_pkg::BK_DIV && dcnt_q == CW'(DW) && dphase_q) begin
			if (fov) begin
				o_num <= '0; o_den <= 31'd1; o_st <= rau_pkg::ST_OVF;
			end else begin
				o_num <= 32'($signed(fnum[W-1:0]));
				o_den <= 31'(fd[W-1:0]);
				o_st <= rau_pkg::ST_OK;
			end
			done_num_q <= 1'b1;
		end else if (state_q == rau_pkg::BK_IDLE) begin
			done_num_q <= 1'b0;
		end
	end

	assign out_ch.valid = (state_q == rau_pkg::BK_DONE);
	assign out_ch.res_num = done_num_q ? o_num : rn_q;
	assign out_ch.res_den = done_num_q ? o_den : rd_q;
	assign out_ch.compare_true = cmp_q;
	assign out_ch.status = done_num_q ? o_st : st_q;

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_ready |-> !out_ch.valid) else $error("accept while result pending");
	a_den_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> out_ch.res_den != '0) else $error("zero denominator out");
	a_cmp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.compare_true |-> out_ch.res_num == '0)
		else $error("compare with nonzero numerator");
endmodule

[rtl/rational_arithmetic_unit.sv]
// Errors and unknown actions go straight to the result; comparisons pass through the multiply
// and combine states; arithmetic adds Euclid steps (gcd) and two divides by the gcd.
// One item in the back end at a time; a two-entry queue holds waiting items.
// The Euclid steps and the final quotients all use the shared 66-step divider.
// arst_n clears queue pointers and the back-end sequencer; datapath holds no reset.
module rational_arithmetic_unit #(
	parameter int unsigned WORD_WIDTH = rau_pkg::WORD_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	rau_in_if.sink    in_ch,
	rau_out_if.source out_ch
);
	logic                       q_valid, q_ready, q_early;
	logic [3:0]                 q_action;
	logic [1:0]                 q_status;
	logic signed [WORD_WIDTH:0] q_an, q_bn;
	logic [WORD_WIDTH:0]        q_ad, q_bd;

	rau_front #(.WORD_WIDTH(WORD_WIDTH)) u_front (
		.clk, .arst_n, .in_ch, .q_valid, .q_ready, .q_action, .q_early,
		.q_status, .q_an, .q_ad, .q_bn, .q_bd
	);

	rau_back #(.WORD_WIDTH(WORD_WIDTH)) u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_action, .q_early,
		.q_status, .q_an, .q_ad, .q_bn, .q_bd, .out_ch
	);
endmodule

[sim/tb.sv]
`timescale 1ns / 100ps

module tb;

	localparam int unsigned STALL_LIMIT = 40000;
	localparam int unsigned N_RANDOM    = 1080;

	typedef struct {
		logic [3:0]  act;
		logic [31:0] an;
		logic [31:0] ad;
		logic [31:0] bn;
		logic [31:0] bd;
	} frac_op_t;

	typedef struct {
		logic [31:0]      num;
		logic [30:0]      den;
		logic             cmp;
		rau_pkg::status_t st;
	} frac_res_t;

	logic clk = 1'b0;
	logic arst_n;

	rau_in_if  in_ch();
	rau_out_if out_ch();

	rational_arithmetic_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	frac_op_t  op_q[$];
	frac_res_t expected_q[$];
	int        errors = 0;
	int        idle_cnt;
	int        src_gap;
	int        snk_gap;
	bit        src_burst;
	bit        snk_burst;

	always #5 clk = ~clk;

	function automatic frac_res_t reduce(bit neg, logic [63:0] mag, logic [63:0] den);
		frac_res_t   r;
		logic [63:0] x;
		logic [63:0] y;
		logic [63:0] t;
		logic [63:0] lim;
		r.num = '0;
		r.den = 31'd1;
		r.cmp = 1'b0;
		r.st  = rau_pkg::ST_OK;
		x = mag;
		y = den;
		while (x != 0) begin
			t = y % x;
			y = x;
			x = t;
		end
		mag = mag / y;
		den = den / y;
		if (mag == 0)
			neg = 1'b0;
		lim = 64'h8000_0000;
		if (den > lim - 1 || (neg ? mag > lim : mag > lim - 1)) begin
			r.st = rau_pkg::ST_OVF;
			return r;
		end
		r.num = neg ? 32'(-mag) : mag[31:0];
		r.den = den[30:0];
		return r;
	endfunction

	function automatic logic [63:0] mag_of(longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic frac_res_t predict_fraction(frac_op_t o);
		frac_res_t   r;
		longint      an, ad, bn, bd, l, rr;
		logic [63:0] lm, rm, mag;
		bit          ln, rn, neg, t;
		r.num = '0;
		r.den = 31'd1;
		r.cmp = 1'b0;
		r.st  = rau_pkg::ST_OK;
		an = $signed(o.an);
		ad = $signed(o.ad);
		bn = $signed(o.bn);
		bd = $signed(o.bd);
		if (o.act > rau_pkg::ACT_GE)
			return r;
		if (ad == 0 || (o.act != rau_pkg::ACT_NORM && bd == 0)) begin
			r.st = rau_pkg::ST_ZDEN;
			return r;
		end
		if (ad < 0) begin
			an = -an;
			ad = -ad;
		end
		if (bd < 0) begin
			bn = -bn;
			bd = -bd;
		end
		case (o.act) inside
			rau_pkg::ACT_NORM: r = reduce(an < 0, mag_of(an), 64'(ad));
			rau_pkg::ACT_ADD, rau_pkg::ACT_SUB: begin
				ln = an < 0;
				rn = (bn < 0) != (o.act == rau_pkg::ACT_SUB);
				if (bn == 0)
					rn = 1'b0;
				lm = mag_of(an) * 64'(bd);
				rm = mag_of(bn) * 64'(ad);
				if (ln == rn) begin
					neg = ln;
					mag = lm + rm;
				end else if (lm >= rm) begin
					neg = ln;
					mag = lm - rm;
				end else begin
					neg = rn;
					mag = rm - lm;
				end
				r = reduce(neg, mag, 64'(ad) * 64'(bd));
			end
			rau_pkg::ACT_MUL: r = reduce((an < 0) != (bn < 0), mag_of(an) * mag_of(bn),
				64'(ad) * 64'(bd));
			rau_pkg::ACT_DIV: begin
				if (bn == 0)
					r.st = rau_pkg::ST_DIV0;
				else
					r = reduce((an < 0) != (bn < 0), mag_of(an) * 64'(bd),
						64'(ad) * mag_of(bn));
			end
			default: begin
				l  = an * bd;
				rr = bn * ad;
				case (o.act)
					rau_pkg::ACT_EQ: t = l == rr;
					rau_pkg::ACT_NE: t = l != rr;
					rau_pkg::ACT_LT: t = l < rr;
					rau_pkg::ACT_LE: t = l <= rr;
					rau_pkg::ACT_GT: t = l > rr;
					default:         t = l >= rr;
				endcase
				r.cmp = t;
			end
		endcase
		return r;
	endfunction

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 60)
			return 0;
		if (p < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return 32'($signed($urandom_range(0, 40)) - 20);
			4, 5, 6:    return $urandom;
			7: begin
				case ($urandom_range(0, 3))
					0: return 32'h8000_0000;
					1: return 32'h7fff_ffff;
					2: return 32'h0000_0001;
					default: return 32'hffff_ffff;
				endcase
			end
			default: return 32'($signed($urandom_range(0, 2000)) - 1000);
		endcase
	endfunction

	task automatic push_op(logic [3:0] act, logic [31:0] an, logic [31:0] ad,
		logic [31:0] bn, logic [31:0] bd);
		frac_op_t o;
		o.act = act;
		o.an  = an;
		o.ad  = ad;
		o.bn  = bn;
		o.bd  = bd;
		op_q.push_back(o);
	endtask

	task automatic report(string field, logic [63:0] got, logic [63:0] exp_v);
		$display("%0t mismatch on %s: got %h, expected %h", $time, field, got, exp_v);
		errors++;
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			src_gap     <= 0;
			src_burst   <= 1'b0;
		end else if (!in_ch.valid || in_ch.ready) begin
			if ($urandom_range(0, 199) == 0)
				src_burst <= ~src_burst;
			if (src_gap > 0) begin
				src_gap     <= src_gap - 1;
				in_ch.valid <= 1'b0;
			end else if (op_q.size() > 0) begin
				frac_op_t o;
				o = op_q.pop_front();
				in_ch.valid  <= 1'b1;
				in_ch.action <= o.act;
				in_ch.a_num  <= o.an;
				in_ch.a_den  <= o.ad;
				in_ch.b_num  <= o.bn;
				in_ch.b_den  <= o.bd;
				src_gap      <= src_burst ? 0 : gap_len();
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// monitor and scoreboard
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			snk_gap      <= 0;
			snk_burst    <= 1'b0;
			idle_cnt     <= 0;
		end else begin
			frac_op_t  o;
			frac_res_t e;
			if ($urandom_range(0, 199) == 0)
				snk_burst <= ~snk_burst;
			if (snk_gap > 0) begin
				snk_gap      <= snk_gap - 1;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
				snk_gap      <= snk_burst ? 0 : gap_len();
			end
			if (in_ch.valid && in_ch.ready) begin
				o.act = in_ch.action;
				o.an  = in_ch.a_num;
				o.ad  = in_ch.a_den;
				o.bn  = in_ch.b_num;
				o.bd  = in_ch.b_den;
				expected_q.push_back(predict_fraction(o));
			end
			if (out_ch.valid && out_ch.ready) begin
				if (expected_q.size() == 0) begin
					report("unexpected beat", 64'(out_ch.res_num), 64'd0);
				end else begin
					e = expected_q.pop_front();
					if (out_ch.res_num !== e.num)
						report("res_num", 64'(out_ch.res_num), 64'(e.num));
					if (out_ch.res_den !== e.den)
						report("res_den", 64'(out_ch.res_den), 64'(e.den));
					if (out_ch.compare_true !== e.cmp)
						report("compare_true", 64'(out_ch.compare_true), 64'(e.cmp));
					if (out_ch.status !== e.st)
						report("status", 64'(out_ch.status), 64'(e.st));
				end
			end
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				idle_cnt <= 0;
			else
				idle_cnt <= idle_cnt + 1;
			if (idle_cnt >= STALL_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		logic [3:0] act;
		int         p;
		arst_n = 1'b0;

		push_op(rau_pkg::ACT_NORM, 32'h8000_0000, 32'd1, 32'd0, 32'd0);
		push_op(rau_pkg::ACT_NORM, 32'hffff_ffff, 32'h8000_0000, 32'd5, 32'd7);
		push_op(rau_pkg::ACT_NORM, 32'h8000_0000, 32'hffff_ffff, 32'd1, 32'd1);
		push_op(rau_pkg::ACT_NORM, 32'd6, -32'sd4, 32'd0, 32'd0);
		push_op(rau_pkg::ACT_NORM, 32'd0, 32'd9, 32'd1, 32'd1);
		push_op(rau_pkg::ACT_ADD, 32'd1, 32'd0, 32'd1, 32'd1);
		push_op(rau_pkg::ACT_MUL, 32'd1, 32'd2, 32'd1, 32'd0);
		push_op(rau_pkg::ACT_DIV, 32'd3, 32'd4, 32'd0, 32'd5);
		push_op(rau_pkg::ACT_DIV, 32'd3, 32'd0, 32'd0, 32'd5);
		push_op(rau_pkg::ACT_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
		push_op(rau_pkg::ACT_ADD, 32'd7, 32'd3, 32'd1, 32'd1);
		push_op(rau_pkg::ACT_SUB, 32'd7, 32'd3, 32'd1, 32'd1);
		push_op(rau_pkg::ACT_SUB, 32'd2, 32'd4, -32'sd1, -32'sd2);
		push_op(rau_pkg::ACT_SUB, 32'd1, 32'd3, -32'sd1, 32'd3);
		push_op(rau_pkg::ACT_ADD, 32'h7fff_ffff, 32'd1, 32'h7fff_ffff, 32'd1);
		push_op(rau_pkg::ACT_MUL, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h8000_0000);
		push_op(rau_pkg::ACT_DIV, -32'sd6, 32'd35, 32'd14, -32'sd15);
		push_op(rau_pkg::ACT_EQ, 32'd1, 32'd2, -32'sd2, -32'sd4);
		push_op(rau_pkg::ACT_NE, 32'd1, 32'd2, 32'd2, 32'd4);
		push_op(rau_pkg::ACT_LT, 32'h8000_0000, 32'd1, 32'h7fff_ffff, 32'd1);
		push_op(rau_pkg::ACT_LE, 32'd1, 32'h7fff_ffff, 32'd1, 32'h8000_0000);
		push_op(rau_pkg::ACT_GT, 32'd1, 32'h7fff_ffff, 32'd1, 32'h8000_0000);
		push_op(rau_pkg::ACT_GE, 32'd3, 32'd5, 32'd6, 32'd10);
		push_op(4'd11, 32'd1, 32'd1, 32'd1, 32'd1);
		push_op(4'd15, 32'd1, 32'd0, 32'd1, 32'd0);

		for (int i = 0; i < N_RANDOM; i++) begin
			p = $urandom_range(0, 99);
			if (p < 3)
				act = 4'($urandom_range(11, 15));
			else if (p < 45)
				act = 4'($urandom_range(0, 4));
			else
				act = 4'($urandom_range(0, 10));
			push_op(act, rand_word(), rand_word(), rand_word(), rand_word());
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (op_q.size() > 0 || in_ch.valid || expected_q.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

[files.f]
rtl/rau_pkg.sv
rtl/rau_if.sv
rtl/rau_front.sv
rtl/rau_back.sv
rtl/rational_arithmetic_unit.sv
sim/tb.sv
